// ===== hw/rtl/assert_macros.svh =====
// ============================================================================
// assert_macros.svh
// Assertion shorthands: clocked, reset-gated implications.
// ============================================================================
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/pctdec_pkg.sv =====
`timescale 1ns / 1ps
// ============================================================================
// pctdec_pkg
// Shared types and constants of the percent-escape decoder.
// ============================================================================
package pctdec_pkg;

    localparam logic [7:0] PCT_CHAR = 8'h25;

    // One decode job: up to three output bytes, in order, from one input word.
    // last applies to the final byte of the job only.
    typedef struct packed {
        logic [2:0][7:0] bytes;
        logic [1:0]      cnt;
        logic            last;
    } job_t;

endpackage

// ===== hw/rtl/pctdec_front.sv =====
`timescale 1ns / 1ps
// ============================================================================
// pctdec_front
// Accept input words, track the escape state and build output jobs.
// ============================================================================
module pctdec_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  logic [7:0]          in_byte,
    input  logic                in_last,
    output logic                push,
    output pctdec_pkg::job_t    push_job
);

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_PCT   = 2'd1,
        PH_DIGIT = 2'd2
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [7:0]  held_char_reg, held_char_next;
    logic [3:0]  held_nib_reg, held_nib_next;

    logic        is_hex;
    logic [3:0]  hex_val;
    logic        run_idle;
    logic [1:0]  pre_cnt;
    pctdec_pkg::job_t job;

    // Hex digit classification: 0-9, A-F, a-f.
    always_comb
    begin
        is_hex  = ((in_byte >= 8'h30) && (in_byte <= 8'h39)) ||
                  ((in_byte >= 8'h41) && (in_byte <= 8'h46)) ||
                  ((in_byte >= 8'h61) && (in_byte <= 8'h66));
        hex_val = in_byte[6] ? 4'(in_byte[3:0] - 4'd1 + 4'd10) : in_byte[3:0];
    end

    always_comb
    begin
        phase_next     = phase_reg;
        held_char_next = held_char_reg;
        held_nib_next  = held_nib_reg;
        job            = '0;
        job.last       = in_last;
        run_idle       = 1'b0;
        pre_cnt        = 2'd0;

        case (phase_reg)
            PH_PCT:
            begin
                if (is_hex) begin
                    if (in_last) begin
                        job.bytes[0] = pctdec_pkg::PCT_CHAR;
                        job.bytes[1] = in_byte;
                        job.cnt      = 2'd2;
                        phase_next   = PH_IDLE;
                    end else begin
                        held_char_next = in_byte;
                        held_nib_next  = hex_val;
                        phase_next     = PH_DIGIT;
                    end
                end else begin
                    job.bytes[0] = pctdec_pkg::PCT_CHAR;
                    pre_cnt      = 2'd1;
                    run_idle     = 1'b1;
                end
            end
            PH_DIGIT:
            begin
                if (is_hex) begin
                    job.bytes[0] = {held_nib_reg, hex_val};
                    job.cnt      = 2'd1;
                    phase_next   = PH_IDLE;
                end else begin
                    job.bytes[0] = pctdec_pkg::PCT_CHAR;
                    job.bytes[1] = held_char_reg;
                    pre_cnt      = 2'd2;
                    run_idle     = 1'b1;
                end
            end
            default:
            begin
                run_idle = 1'b1;
            end
        endcase

        // Handle the current byte with no escape pending.
        if (run_idle) begin
            if ((in_byte == pctdec_pkg::PCT_CHAR) && !in_last) begin
                job.cnt    = pre_cnt;
                phase_next = PH_PCT;
            end else begin
                case (pre_cnt)
                    2'd0:    job.bytes[0] = in_byte;
                    2'd1:    job.bytes[1] = in_byte;
                    default: job.bytes[2] = in_byte;
                endcase
                job.cnt    = 2'(pre_cnt + 2'd1);
                phase_next = PH_IDLE;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg     <= PH_IDLE;
            held_char_reg <= '0;
            held_nib_reg  <= '0;
        end else if (accept) begin
            phase_reg     <= phase_next;
            held_char_reg <= held_char_next;
            held_nib_reg  <= held_nib_next;
        end
    end

    assign push     = accept && (job.cnt != 2'd0);
    assign push_job = job;

endmodule

// ===== hw/rtl/pctdec_fifo.sv =====
`timescale 1ns / 1ps
// ============================================================================
// pctdec_fifo
// Short job queue between front and back end.
// ============================================================================
module pctdec_fifo #(
    parameter int DEPTH = 4
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  pctdec_pkg::job_t    push_job,
    input  logic                pop,
    output pctdec_pkg::job_t    head,
    output logic                nonempty,
    output logic                full
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    pctdec_pkg::job_t  mem_reg [DEPTH];
    logic [AW-1:0]     wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0]     count_reg;

    function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] p);
        wrap_inc = (p == AW'(DEPTH - 1)) ? '0 : AW'(p + 1'b1);
    endfunction

    always_ff @(posedge clk)
    begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wrap_inc(wr_ptr_reg);
            end
            if (pop) begin
                rd_ptr_reg <= wrap_inc(rd_ptr_reg);
            end
            if (push && !pop) begin
                count_reg <= CW'(count_reg + 1'b1);
            end else if (pop && !push) begin
                count_reg <= CW'(count_reg - 1'b1);
            end
        end
    end

    assign head     = mem_reg[rd_ptr_reg];
    assign nonempty = (count_reg != '0);
    assign full     = (count_reg == CW'(DEPTH));

endmodule

// ===== hw/rtl/pctdec_back.sv =====
`timescale 1ns / 1ps
// ============================================================================
// pctdec_back
// Unpack jobs into single output bytes behind an output register.
// ============================================================================
module pctdec_back (
    input  logic                clk,
    input  logic                rst_n,
    input  pctdec_pkg::job_t    head,
    input  logic                head_valid,
    output logic                pop,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [7:0]          out_byte,
    output logic                out_last
);

    pctdec_pkg::job_t  cur_reg, cur_next;
    logic              cur_valid_reg, cur_valid_next;
    logic [1:0]        idx_reg, idx_next;
    logic              out_valid_reg, out_valid_next;
    logic [7:0]        out_byte_reg, out_byte_next;
    logic              out_last_reg, out_last_next;

    pctdec_pkg::job_t  src;
    logic [1:0]        sel;
    logic              load;
    logic              done;
    logic [7:0]        pick;

    always_comb
    begin
        src  = cur_valid_reg ? cur_reg : head;
        sel  = cur_valid_reg ? idx_reg : 2'd0;
        load = (cur_valid_reg || head_valid) && (!out_valid_reg || out_ready);
        done = (2'(sel + 2'd1) == src.cnt);

        case (sel)
            2'd0:    pick = src.bytes[0];
            2'd1:    pick = src.bytes[1];
            default: pick = src.bytes[2];
        endcase

        cur_next       = cur_reg;
        cur_valid_next = cur_valid_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        out_byte_next  = out_byte_reg;
        out_last_next  = out_last_reg;

        if (load) begin
            out_valid_next = 1'b1;
            out_byte_next  = pick;
            out_last_next  = done && src.last;
            if (done) begin
                cur_valid_next = 1'b0;
            end else begin
                cur_valid_next = 1'b1;
                cur_next       = src;
                idx_next       = 2'(sel + 2'd1);
            end
        end else if (out_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cur_valid_reg <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            cur_valid_reg <= cur_valid_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg      <= cur_next;
        out_byte_reg <= out_byte_next;
        out_last_reg <= out_last_next;
    end

    assign pop       = load && !cur_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign out_last  = out_last_reg;

endmodule

// ===== hw/rtl/percent_hex_decoder.sv =====
`timescale 1ns / 1ps
// ============================================================================
// percent_hex_decoder
// Streaming percent-escape (%XY) decoder, one encoded byte per word.
// ============================================================================
// Usage:
//   Input channel in_valid/in_ready carries in_byte plus in_last on the final
//   byte of a string. Output channel out_valid/out_ready carries out_byte plus
//   out_last on the final decoded byte.
//   A well-formed escape "%XY" yields one byte; a broken escape passes the
//   '%' and any held digit through literally, then the breaking byte is
//   handled afresh. One input word gives zero to three output words.
// Throughput: one input word per cycle while each word yields at most one
//   output and out_ready is high; a word with several outputs holds the port
//   until all are sent. The output register loads one byte per cycle while
//   out_ready is high, which sets the peak rate.
// Path: an accepted word's job enters the queue, then the output register.
// Stall: when out_ready is low the output register holds; jobs collect in
//   the QUEUE_DEPTH-entry queue and in_ready drops once the queue is full.
// Reset: rst_n clears the escape state, queue and output valid; the block
//   is ready for a new string on the first cycle after reset.
// ============================================================================
module percent_hex_decoder #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  in_byte,
    input  logic        in_last,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  out_byte,
    output logic        out_last
);

    logic               accept;
    logic               push;
    pctdec_pkg::job_t   push_job;
    logic               pop;
    pctdec_pkg::job_t   head;
    logic               head_valid;
    logic               full;

    // Take a word whenever the queue has room for its job.
    assign in_ready = !full;
    assign accept   = in_valid && in_ready;

    // Front end: classify the byte, advance the escape state, build a job.
    pctdec_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .in_byte  (in_byte),
        .in_last  (in_last),
        .push     (push),
        .push_job (push_job)
    );

    // Job queue: decouple input acceptance from output stalls.
    pctdec_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head     (head),
        .nonempty (head_valid),
        .full     (full)
    );

    // Back end: drain jobs to the output register, a byte per cycle if out_ready.
    pctdec_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .head_valid (head_valid),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_byte   (out_byte),
        .out_last   (out_last)
    );

endmodule

// ===== hw/rtl/pctdec_checker.sv =====
`timescale 1ns / 1ps
// ============================================================================
// pctdec_checker
// Port-level checks of the percent-escape decoder.
// ============================================================================
`include "assert_macros.svh"

module pctdec_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic        in_last,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [7:0]  out_byte,
    input  logic        out_last
);

    logic [3:0] open_strings_reg, open_strings_next;
    logic       in_end, out_end;

    assign in_end  = in_valid && in_ready && in_last;
    assign out_end = out_valid && out_ready && out_last;

    // Count strings whose final input byte is in but final output not yet out.
    always_comb
    begin
        open_strings_next = open_strings_reg;
        if (in_end && !out_end) begin
            open_strings_next = 4'(open_strings_reg + 4'd1);
        end else if (out_end && !in_end) begin
            open_strings_next = 4'(open_strings_reg - 4'd1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            open_strings_reg <= '0;
        end else begin
            open_strings_reg <= open_strings_next;
        end
    end

    `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready,
        out_valid && $stable(out_byte) && $stable(out_last), "output word changed while stalled")
    `ASSERT_SAME(a_last_follows_input, clk, rst_n, out_end,
        open_strings_reg != 4'd0, "end of string delivered before its final input")
    `ASSERT_SAME(a_ready_when_drained, clk, rst_n, !out_valid,
        in_ready, "input stalled while output side is empty")

endmodule

bind percent_hex_decoder pctdec_checker u_pctdec_checker (.*);
